@@ rtl/core/sts_pkg.sv @@
// shared constants and types for the degree-input taylor sine core
package sts_pkg;

    localparam int ANGLE_W  = 10;
    localparam int SINE_W   = 18;
    localparam int TERMS_W  = 5;
    localparam int THR_W    = 8;

    // operand chunk width of the shared multiplier
    localparam int CHUNK_W  = 16;

    // radians per degree in q60
    localparam int RPD_W    = 55;
    localparam int RPD_FRAC = 60;
    localparam logic [RPD_W-1:0] RPD_Q60 = 55'd20122276272436452;

    typedef enum logic [1:0] {
        M_XM,
        M_X2,
        M_TERM
    } t_mode;

endpackage

@@ rtl/core/sine_taylor_series_degrees.sv @@
// taylor series sine of an integer angle in degrees, one shared multiply-accumulate unit
//
//  channel   direction  handshake                  payload
//  input     in         i_valid / o_stall          i_angle_deg
//  result    out        o_valid / i_stall          o_sine_value, o_terms_used, o_limit_hit
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_stop_threshold
//
// every multiply runs MSB chunk first through one W x 16 multiplier in 4 passes, every
// term divide retires one quotient bit per cycle; those two loops set the time a beat takes.
// synchronous active-low reset clears the sequencer, the result valid and stop_threshold.
// o_stall is high from accept until the result is in the output register; a stalled
// result holds while the next beat is taken and worked on.
module sine_taylor_series_degrees #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_TERMS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [sts_pkg::ANGLE_W-1:0] i_angle_deg,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [sts_pkg::SINE_W-1:0]  o_sine_value,
    output logic [sts_pkg::TERMS_W-1:0]        o_terms_used,
    output logic                               o_limit_hit,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sts_pkg::THR_W-1:0]          i_cfg_stop_threshold
);
    import sts_pkg::*;

    // term magnitude stays below 1024 in the angle range, x^2 below 81
    localparam int W     = FRAC_BITS + 11;
    localparam int X2W   = FRAC_BITS + 7;
    localparam int SW    = W + 1;
    localparam int BMAX  = (RPD_W > X2W) ? RPD_W : X2W;
    localparam int NCH   = (BMAX + CHUNK_W - 1) / CHUNK_W;
    localparam int BW    = NCH * CHUNK_W;
    localparam int AW    = W + BW;
    localparam int XM_SH = RPD_FRAC - FRAC_BITS;
    localparam int NW    = $clog2(2 * MAX_TERMS);
    localparam int DW    = $clog2((2 * MAX_TERMS - 1) * (2 * MAX_TERMS - 2) + 1);
    localparam int CNTW  = $clog2(MAX_TERMS + 1);
    localparam int SCW   = $clog2(W + 1);

    localparam logic signed [SW-1:0] ONE_Q = SW'(2 ** FRAC_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    t_mode                r_mode;
    logic                 r_neg;
    logic [W-1:0]         r_a;
    logic [BW-1:0]        r_b;
    logic [AW-1:0]        r_acc;
    logic [SCW-1:0]       r_cnt;
    logic [W-1:0]         r_term;
    logic [X2W-1:0]       r_x2;
    logic signed [SW-1:0] r_sum;
    logic                 r_minus;
    logic [CNTW-1:0]      r_count;
    logic                 r_limit;
    logic [NW-1:0]        r_n;
    logic [DW-1:0]        r_dv;
    logic [DW-1:0]        r_rem;
    logic [W-1:0]         r_num;
    logic [THR_W-1:0]     r_thr;
    logic                 r_out_valid;
    logic [SINE_W-1:0]    r_sine;
    logic [TERMS_W-1:0]   r_terms;
    logic                 r_lim_o;

    logic [ANGLE_W-1:0]     angle_mag;
    logic [CHUNK_W-1:0]     chunk;
    logic [W+CHUNK_W-1:0]   pp;
    logic [AW-1:0]          acc_mac;
    logic [AW-1:0]          rnd_c;
    logic [AW-1:0]          acc_rnd;
    logic [AW-1:0]          res;
    logic [DW:0]            trial;
    logic                   q_bit;
    logic [DW:0]            diff;
    logic [DW-1:0]          rem_step;
    logic signed [SW-1:0]   term_ext;
    logic signed [SW-1:0]   sum_step;
    logic signed [SW-1:0]   clamped;
    logic signed [SW-1:0]   sine_full;
    logic                   small_term;
    logic                   at_limit;
    logic                   out_free;
    logic                   in_beat;

    assign in_beat  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    assign angle_mag = i_angle_deg[ANGLE_W-1] ? (ANGLE_W'(~i_angle_deg) + ANGLE_W'(1))
                                              : ANGLE_W'(i_angle_deg);

    // shared unit: msb chunk first, shift then accumulate
    assign chunk   = r_b[BW-1 -: CHUNK_W];
    assign pp      = r_a * chunk;
    assign acc_mac = {r_acc[AW-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + AW'(pp);

    // the term step folds the +d/2 of the divide rounding in above the fraction bits
    always_comb begin
        unique case (r_mode)
            M_XM:    rnd_c = AW'(1) << (XM_SH - 1);
            M_X2:    rnd_c = AW'(1) << (FRAC_BITS - 1);
            M_TERM:  rnd_c = (AW'(r_dv >> 1) << FRAC_BITS) | (AW'(1) << (FRAC_BITS - 1));
            default: rnd_c = '0;
        endcase
    end

    assign acc_rnd = r_acc + rnd_c;
    assign res     = (r_mode == M_XM) ? (acc_rnd >> XM_SH) : (acc_rnd >> FRAC_BITS);

    // restoring divide by n(n-1), one quotient bit per cycle
    assign trial    = {r_rem, r_num[W-1]};
    assign q_bit    = (trial >= {1'b0, r_dv});
    assign diff     = trial - {1'b0, r_dv};
    assign rem_step = q_bit ? diff[DW-1:0] : trial[DW-1:0];

    assign term_ext = $signed({1'b0, r_num});
    assign sum_step = r_minus ? (r_sum - term_ext) : (r_sum + term_ext);

    assign small_term = (r_term <= W'(r_thr));
    assign at_limit   = (r_count >= CNTW'(MAX_TERMS));

    always_comb begin
        if (r_sum > ONE_Q) begin
            clamped = ONE_Q;
        end else if (r_sum < -ONE_Q) begin
            clamped = -ONE_Q;
        end else begin
            clamped = r_sum;
        end
        sine_full = r_neg ? -clamped : clamped;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_MUL;
            end
            S_MUL: begin
                if (r_cnt == '0) n_state = S_RND;
            end
            S_RND: begin
                unique case (r_mode)
                    M_XM:    n_state = S_MUL;
                    M_X2:    n_state = S_CHK;
                    M_TERM:  n_state = S_DIV;
                    default: n_state = S_IDLE;
                endcase
            end
            S_CHK: begin
                if (small_term || at_limit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_ADD;
            end
            S_ADD: n_state = S_CHK;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) r_thr <= i_cfg_stop_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    r_neg   <= i_angle_deg[ANGLE_W-1];
                    r_a     <= W'(angle_mag);
                    r_b     <= BW'(RPD_Q60);
                    r_acc   <= '0;
                    r_cnt   <= SCW'(NCH - 1);
                    r_mode  <= M_XM;
                    r_n     <= NW'(3);
                    r_dv    <= DW'(6);
                    r_count <= CNTW'(1);
                    r_minus <= 1'b1;
                    r_limit <= 1'b0;
                end
            end
            S_MUL: begin
                r_acc <= acc_mac;
                r_b   <= r_b << CHUNK_W;
                r_cnt <= r_cnt - SCW'(1);
            end
            S_RND: begin
                unique case (r_mode)
                    M_XM: begin
                        r_term <= res[W-1:0];
                        r_sum  <= $signed({1'b0, res[W-1:0]});
                        r_a    <= res[W-1:0];
                        r_b    <= BW'(res[W-1:0]);
                        r_acc  <= '0;
                        r_cnt  <= SCW'(NCH - 1);
                        r_mode <= M_X2;
                    end
                    M_X2: begin
                        r_x2 <= res[X2W-1:0];
                    end
                    M_TERM: begin
                        r_rem <= res[W+DW-1:W];
                        r_num <= res[W-1:0];
                        r_cnt <= SCW'(W - 1);
                    end
                    default: ;
                endcase
            end
            S_CHK: begin
                if (small_term) begin
                    r_limit <= 1'b0;
                end else if (at_limit) begin
                    r_limit <= 1'b1;
                end else begin
                    r_a    <= r_term;
                    r_b    <= BW'(r_x2);
                    r_acc  <= '0;
                    r_cnt  <= SCW'(NCH - 1);
                    r_mode <= M_TERM;
                end
            end
            S_DIV: begin
                r_rem <= rem_step;
                r_num <= {r_num[W-2:0], q_bit};
                r_cnt <= r_cnt - SCW'(1);
            end
            S_ADD: begin
                r_term  <= r_num;
                r_sum   <= sum_step;
                r_minus <= ~r_minus;
                r_count <= r_count + CNTW'(1);
                // (n+2)(n+1) = n(n-1) + 4n + 2
                r_dv    <= r_dv + DW'({r_n, 2'b10});
                r_n     <= r_n + NW'(2);
            end
            S_DONE: begin
                if (out_free) begin
                    r_sine  <= sine_full[SINE_W-1:0];
                    r_terms <= TERMS_W'(r_count);
                    r_lim_o <= r_limit;
                end
            end
            default: ;
        endcase
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_sine_value = r_sine;
    assign o_terms_used = r_terms;
    assign o_limit_hit  = r_lim_o;
    assign o_cfg_ready  = 1'b1;

endmodule

@@ rtl/core/sts_checker.sv @@
// port-level checks for the taylor sine core, bound to its top level
module sts_checker #(
    parameter int MAX_TERMS = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [sts_pkg::SINE_W-1:0]  o_sine_value,
    input logic [sts_pkg::TERMS_W-1:0]        o_terms_used,
    input logic                               o_limit_hit
);
    import sts_pkg::*;

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // an accepted beat holds off the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // the limit flag only comes with the full term count
    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_limit_hit) |-> (o_terms_used == TERMS_W'(MAX_TERMS)))
        else $error("limit flag without full term count");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sine_value)
                                  && $stable(o_terms_used) && $stable(o_limit_hit)))
        else $error("stalled result changed");

endmodule

bind sine_taylor_series_degrees sts_checker #(.MAX_TERMS(MAX_TERMS)) u_sts_checker (.*);
